// ----- hw/rtl/fte_pkg.sv -----
// Package for the FAT12 allocation table engine.
// Holds table geometry, mode and status codes, and the row access request type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fte_pkg;

    // Table geometry
    localparam int TABLE_SIZE_BYTES   = 512;
    localparam int CLUSTER_SIZE_BYTES = 4096;
    localparam int CLUSTER_SHIFT      = $clog2(CLUSTER_SIZE_BYTES);

    localparam int ENTRY_W    = 12;
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 32;
    localparam int CNT_W      = 21;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;

    // Entries that fit: entry*3/2 + 1 < TABLE_SIZE_BYTES
    localparam int ENTRY_LIMIT = (2 * TABLE_SIZE_BYTES - 3) / 3 + 1;
    // One row holds an entry pair (three table bytes)
    localparam int ROW_COUNT   = (ENTRY_LIMIT + 1) / 2;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int ROW_DATA_W  = 2 * ENTRY_W;

    // Byte address / 3 as multiply by reciprocal, exact for IDX_W-bit addresses
    localparam int DIV3_MUL    = (2 ** IDX_W) / 3 + 1;
    localparam int PROD_W      = 2 * IDX_W;

    // Special entry values
    localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 12'hFFF;
    localparam logic [ENTRY_W-1:0] MEDIA_ENTRY  = 12'hFF8;
    localparam logic [ROW_DATA_W-1:0] RESET_ROW0 = {END_OF_CHAIN, MEDIA_ENTRY};
    localparam logic [IDX_W-1:0] FIRST_FREE     = 9'd2;

    // Modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Row access request from the sequencer to the row store
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic [ROW_W-1:0]      addr;
        logic [ROW_DATA_W-1:0] wdata;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fte_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fte_row_store.sv -----
// Row store: entry-pair memory plus per-row valid bits giving the reset image.
// Depends on fte_pkg and fte_ram.
`timescale 1ns / 1ps
`default_nettype none

module fte_row_store
    import fte_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mem_req_t              req,
    output logic [ROW_DATA_W-1:0]      rd_row
);

    logic [ROW_COUNT-1:0]  valid_reg;
    logic                  rd_valid_reg;
    logic                  rd_zero_reg;
    logic [ROW_DATA_W-1:0] ram_q;

    fte_ram #(
        .WIDTH(ROW_DATA_W),
        .DEPTH(ROW_COUNT)
    ) u_ram (
        .aclk (aclk),
        .rd_en(req.rd_en),
        .wr_en(req.wr_en),
        .addr (req.addr),
        .wdata(req.wdata),
        .rdata(ram_q)
    );

    // Valid bits: a row never written reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    // Track validity of the row being read, aligned with RAM output
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_valid_reg <= valid_reg[req.addr];
            rd_zero_reg  <= (req.addr == '0);
        end
    end

    assign rd_row = rd_valid_reg ? ram_q : (rd_zero_reg ? RESET_ROW0 : '0);

endmodule

`default_nettype wire

// ----- hw/rtl/fat12_table_engine.sv -----
// FAT12 allocation table engine: sequencer, output register and row store; uses fte_pkg.
// Each transaction runs S_IDLE, S_START, then S_DONE; an index error, zero length or
// refused allocation goes straight to S_DONE, entry/raw reads and writes pass S_RD/S_WR
// once, allocations once per table row touched (one read-modify-write per entry pair).
// One transaction in flight: s_tready is high only in S_IDLE, entered from S_DONE when
// the output register is free. Reset: entries 0/1 = 0xFF8/0xFFF via row valid bits.
`timescale 1ns / 1ps
`default_nettype none

module fat12_table_engine
    import fte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: mode[1:0], index[10:2], value[22:11], length_bytes[54:23], pad[55]
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: status[1:0], data[13:2], chain_head[22:14], cluster_count[43:23], pad
    output logic [47:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            state_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [IDX_W-1:0]      index_reg;
    logic [ENTRY_W-1:0]    value_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      next_free_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [IDX_W-1:0]      end_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ENTRY_W-1:0]    data_reg;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [ENTRY_W-1:0]    out_data_reg;
    logic [IDX_W-1:0]      out_first_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic                  s_accept;
    logic                  out_free;
    logic [LEN_W-1:0]      s_len;
    logic [CNT_W-1:0]      s_cnt;
    logic [PROD_W-1:0]     div3_prod;
    logic [ROW_W-1:0]      raw_row;
    logic [IDX_W:0]        raw_rem;
    logic [CNT_W:0]        alloc_sum;
    logic [ROW_DATA_W-1:0] rd_row;
    logic [ROW_DATA_W-1:0] alloc_row;
    logic [ROW_DATA_W-1:0] write_row;
    logic [BYTE_W-1:0]     raw_byte;
    mem_req_t              mem_req;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid || m_tready;

    // Cluster count: round length up to whole clusters
    assign s_len = s_tdata[54:23];
    assign s_cnt = CNT_W'(s_len >> CLUSTER_SHIFT)
                 + CNT_W'(|s_len[CLUSTER_SHIFT-1:0]);

    // Raw byte address -> row (address / 3) and byte within the row
    assign div3_prod = PROD_W'(index_reg) * PROD_W'(DIV3_MUL);
    assign raw_row   = ROW_W'(div3_prod >> IDX_W);
    assign raw_rem   = {1'b0, index_reg} - ((IDX_W+1)'(row_reg)
                     + (IDX_W+1)'({row_reg, 1'b0}));

    always_comb begin
        case (raw_rem[1:0])
            2'd0:    raw_byte = rd_row[7:0];
            2'd1:    raw_byte = rd_row[15:8];
            default: raw_byte = rd_row[23:16];
        endcase
    end

    assign alloc_sum = (CNT_W+1)'(next_free_reg) + (CNT_W+1)'(cnt_reg);

    // Chain links for both entries of the current row
    always_comb begin
        logic [IDX_W-1:0] ent;
        alloc_row = rd_row;
        for (int h = 0; h < 2; h++) begin
            ent = {row_reg, h[0]};
            if (ent >= first_reg && ent <= end_reg) begin
                alloc_row[h*ENTRY_W +: ENTRY_W] =
                    (ent == end_reg) ? END_OF_CHAIN : ENTRY_W'(ent) + 1'b1;
            end
        end
    end

    // Single entry write replaces only its own half of the row
    assign write_row = index_reg[0] ? {value_reg, rd_row[ENTRY_W-1:0]}
                                    : {rd_row[ROW_DATA_W-1:ENTRY_W], value_reg};

    // Row store requests
    always_comb begin
        mem_req.rd_en = (state_reg == S_RD);
        mem_req.wr_en = (state_reg == S_WR)
                     && (mode_reg == MODE_WRITE || mode_reg == MODE_ALLOC);
        mem_req.addr  = row_reg;
        mem_req.wdata = (mode_reg == MODE_ALLOC) ? alloc_row : write_row;
    end

    fte_row_store u_store (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            next_free_reg <= FIRST_FREE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        mode_reg  <= s_tdata[1:0];
                        index_reg <= s_tdata[10:2];
                        value_reg <= s_tdata[22:11];
                        cnt_reg   <= (s_tdata[1:0] == MODE_ALLOC) ? s_cnt : '0;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    data_reg <= '0;
                    case (mode_reg)
                        MODE_READ, MODE_WRITE: begin
                            first_reg <= '0;
                            if (32'(index_reg) < ENTRY_LIMIT) begin
                                status_reg <= STATUS_OK;
                                row_reg    <= index_reg[IDX_W-1:1];
                                state_reg  <= S_RD;
                            end else begin
                                status_reg <= STATUS_INDEX;
                                state_reg  <= S_DONE;
                            end
                        end
                        MODE_RAW: begin
                            first_reg <= '0;
                            if (32'(index_reg) < TABLE_SIZE_BYTES) begin
                                status_reg <= STATUS_OK;
                                row_reg    <= raw_row;
                                state_reg  <= S_RD;
                            end else begin
                                status_reg <= STATUS_INDEX;
                                state_reg  <= S_DONE;
                            end
                        end
                        default: begin
                            if (cnt_reg == '0) begin
                                status_reg <= STATUS_OK;
                                first_reg  <= '0;
                                state_reg  <= S_DONE;
                            end else if (alloc_sum > (CNT_W+1)'(ENTRY_LIMIT)) begin
                                status_reg <= STATUS_FULL;
                                first_reg  <= '0;
                                state_reg  <= S_DONE;
                            end else begin
                                status_reg <= STATUS_OK;
                                first_reg  <= next_free_reg;
                                end_reg    <= IDX_W'(alloc_sum - 1'b1);
                                row_reg    <= next_free_reg[IDX_W-1:1];
                                state_reg  <= S_RD;
                            end
                        end
                    endcase
                end
                S_RD: begin
                    state_reg <= S_WR;
                end
                S_WR: begin
                    case (mode_reg)
                        MODE_READ: begin
                            data_reg  <= index_reg[0] ? rd_row[ROW_DATA_W-1:ENTRY_W]
                                                      : rd_row[ENTRY_W-1:0];
                            state_reg <= S_DONE;
                        end
                        MODE_RAW: begin
                            data_reg  <= ENTRY_W'(raw_byte);
                            state_reg <= S_DONE;
                        end
                        MODE_ALLOC: begin
                            if (row_reg == end_reg[IDX_W-1:1]) begin
                                next_free_reg <= end_reg + 1'b1;
                                state_reg     <= S_DONE;
                            end else begin
                                row_reg   <= row_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            out_status_reg <= status_reg;
            out_data_reg   <= data_reg;
            out_first_reg  <= first_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign m_tdata = {4'b0, out_count_reg, out_first_reg, out_data_reg, out_status_reg};

    // Every table write is the second half of a read-modify-write
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> $past(mem_req.rd_en))
        else $error("table write without preceding row read");

    // The free pointer never runs more than one past the last entry that fits
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(next_free_reg) <= ENTRY_LIMIT)
        else $error("next free cluster beyond table");

    // Allocation never walks past the row holding the chain end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR && mode_reg == MODE_ALLOC)
            |-> row_reg <= end_reg[IDX_W-1:1])
        else $error("allocation row beyond chain end");

endmodule

`default_nettype wire

// ----- test/fat12_table_checker.sv -----
// Scoreboard for the FAT12 table engine: watches both stream channels,
// keeps its own copy of the table and free pointer, and checks every result.
// Depends on fte_pkg.
`timescale 1ns / 1ps

module fat12_table_checker
    import fte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    output int          fail_count,
    output int          pending
);

    // Field layouts, last field in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]   length_bytes;
        logic [ENTRY_W-1:0] value;
        logic [IDX_W-1:0]   index;
        logic [MODE_W-1:0]  mode;
    } fat_request_t;

    typedef struct packed {
        logic [CNT_W-1:0]    cluster_count;
        logic [IDX_W-1:0]    chain_head;
        logic [ENTRY_W-1:0]  data;
        logic [STATUS_W-1:0] status;
    } fat_result_t;

    logic [BYTE_W-1:0] fat_bytes [TABLE_SIZE_BYTES];
    logic [IDX_W-1:0]  free_cluster;
    fat_result_t       result_q [$];
    fat_result_t       wanted;
    fat_result_t       observed;
    fat_request_t      request;
    int                mismatches;

    // Both bytes of the entry must lie inside the table
    function automatic bit entry_in_table(longint unsigned entry);
        return entry * 3 / 2 + 1 < TABLE_SIZE_BYTES;
    endfunction

    function automatic logic [ENTRY_W-1:0] entry_get(int unsigned entry);
        int unsigned lo;
        lo = entry * 3 / 2;
        if (entry[0]) begin
            return {fat_bytes[lo + 1], fat_bytes[lo][7:4]};
        end
        return {fat_bytes[lo + 1][3:0], fat_bytes[lo]};
    endfunction

    // Replace only the nibbles owned by this entry
    function automatic void entry_put(int unsigned entry, logic [ENTRY_W-1:0] val);
        int unsigned lo;
        lo = entry * 3 / 2;
        if (entry[0]) begin
            fat_bytes[lo]     = {val[3:0], fat_bytes[lo][3:0]};
            fat_bytes[lo + 1] = val[11:4];
        end else begin
            fat_bytes[lo]     = val[7:0];
            fat_bytes[lo + 1] = {fat_bytes[lo + 1][7:4], val[11:8]};
        end
    endfunction

    // Apply one request to the table copy and return its result
    function automatic fat_result_t apply_request(fat_request_t req);
        fat_result_t     res;
        longint unsigned len64;
        longint unsigned clusters;
        longint unsigned last;
        longint unsigned c;
        res = '0;
        case (req.mode)
            MODE_READ: begin
                if (entry_in_table(req.index)) begin
                    res.data = entry_get(req.index);
                end else begin
                    res.status = STATUS_INDEX;
                end
            end
            MODE_WRITE: begin
                if (entry_in_table(req.index)) begin
                    entry_put(req.index, req.value);
                end else begin
                    res.status = STATUS_INDEX;
                end
            end
            MODE_RAW: begin
                if (req.index < TABLE_SIZE_BYTES) begin
                    res.data = {4'h0, fat_bytes[req.index]};
                end else begin
                    res.status = STATUS_INDEX;
                end
            end
            default: begin
                len64    = req.length_bytes;
                clusters = (len64 + CLUSTER_SIZE_BYTES - 1) / CLUSTER_SIZE_BYTES;
                res.cluster_count = clusters[CNT_W-1:0];
                if (clusters != 0) begin
                    last = free_cluster + clusters - 1;
                    if (!entry_in_table(last)) begin
                        // refused whole, nothing written
                        res.status = STATUS_FULL;
                    end else begin
                        for (c = free_cluster; c < last; c++) begin
                            entry_put(c, ENTRY_W'(c + 1));
                        end
                        entry_put(last, END_OF_CHAIN);
                        res.chain_head = free_cluster;
                        free_cluster   = IDX_W'(last + 1);
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Track both channels; results are checked before a new request is queued
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (fat_bytes[i]) begin
                fat_bytes[i] = '0;
            end
            entry_put(0, MEDIA_ENTRY);
            entry_put(1, END_OF_CHAIN);
            free_cluster = FIRST_FREE;
            result_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                observed = fat_result_t'(m_tdata[43:0]);
                if (result_q.size() == 0) begin
                    $error("result transaction 0x%0h with no expectation pending", m_tdata);
                    mismatches++;
                end else begin
                    wanted = result_q.pop_front();
                    check_field("status", wanted.status, observed.status);
                    check_field("data", wanted.data, observed.data);
                    check_field("chain_head", wanted.chain_head,
                                observed.chain_head);
                    check_field("cluster_count", wanted.cluster_count,
                                observed.cluster_count);
                end
            end
            if (s_tvalid && s_tready) begin
                request = fat_request_t'(s_tdata[54:0]);
                result_q.push_back(apply_request(request));
            end
        end
        fail_count <= mismatches;
        pending    <= result_q.size();
    end

endmodule

// ----- test/fat12_table_engine_test.sv -----
// Top of the FAT12 table engine testbench: clock, reset, stimulus and verdict.
// Depends on fte_pkg, fat12_table_engine and fat12_table_checker.
`timescale 1ns / 1ps

module fat12_table_engine_test;
    import fte_pkg::*;

    localparam int RANDOM_ITEMS = 745;
    localparam int FILL_ITEMS   = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;

    int fail_count;
    int pending;
    int idle_cycles;
    bit steady;

    fat12_table_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    fat12_table_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones; none during a steady stretch
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction after a random gap and hold it until taken
    task automatic send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                             logic [ENTRY_W-1:0] val, logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, len, val, idx, mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random mix: reads, writes, raw reads and small allocations with noise
    task automatic send_random_item();
        int unsigned      pick;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 8) begin
            idx = IDX_W'($urandom_range(0, ENTRY_LIMIT - 1));
        end else begin
            idx = IDX_W'($urandom);
        end
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = $urandom;
            default: len = $urandom_range(1, 3 * CLUSTER_SIZE_BYTES);
        endcase
        if (pick < 35) begin
            send_item(MODE_READ, idx, ENTRY_W'($urandom), $urandom);
        end else if (pick < 55) begin
            send_item(MODE_WRITE, idx, ENTRY_W'($urandom), $urandom);
        end else if (pick < 80) begin
            send_item(MODE_RAW, IDX_W'($urandom), ENTRY_W'($urandom), $urandom);
        end else begin
            send_item(MODE_ALLOC, IDX_W'($urandom), ENTRY_W'($urandom), len);
        end
    endtask

    // Result side back-pressure
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        steady   = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reserved entries and raw bytes after reset
        send_item(MODE_READ, 9'd0, 12'h000, 32'h0);
        send_item(MODE_READ, 9'd1, 12'hFFF, 32'hFFFF_FFFF);
        send_item(MODE_RAW, 9'd0, 12'h000, 32'h0);
        send_item(MODE_RAW, 9'd2, 12'h000, 32'h0);
        // Last entry in the table and entries past it
        send_item(MODE_READ, 9'd340, 12'h000, 32'h0);
        send_item(MODE_READ, 9'd341, 12'h000, 32'h0);
        send_item(MODE_READ, 9'd511, 12'h000, 32'h0);
        send_item(MODE_WRITE, 9'd341, 12'hABC, 32'h0);
        send_item(MODE_WRITE, 9'd340, 12'hFFF, 32'h0);
        send_item(MODE_RAW, 9'd510, 12'h000, 32'h0);
        send_item(MODE_RAW, 9'd511, 12'h000, 32'h0);
        // Odd/even neighbors share a byte; writes must keep the other nibble
        send_item(MODE_WRITE, 9'd3, 12'hABC, 32'h0);
        send_item(MODE_WRITE, 9'd2, 12'h123, 32'h0);
        send_item(MODE_READ, 9'd3, 12'h000, 32'h0);
        send_item(MODE_RAW, 9'd4, 12'h000, 32'h0);
        // Zero length, exact and partial clusters, oversize requests
        send_item(MODE_ALLOC, 9'd0, 12'h000, 32'd0);
        send_item(MODE_ALLOC, 9'd0, 12'h000, 32'd1);
        send_item(MODE_ALLOC, 9'd0, 12'h000, CLUSTER_SIZE_BYTES);
        send_item(MODE_ALLOC, 9'd0, 12'h000, CLUSTER_SIZE_BYTES + 1);
        send_item(MODE_ALLOC, 9'd0, 12'h000, 32'hFFFF_FFFF);
        send_item(MODE_ALLOC, 9'd0, 12'h000, 341 * CLUSTER_SIZE_BYTES);
        send_item(MODE_READ, 9'd4, 12'h000, 32'h0);
        send_item(MODE_READ, 9'd5, 12'h000, 32'h0);
        send_item(MODE_WRITE, 9'd0, 12'h000, 32'h0);
        send_item(MODE_READ, 9'd0, 12'h000, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 400 && i < 480);
            send_random_item();
        end
        steady = 1'b0;

        // Single-cluster allocations walk the pointer to an exact fill
        for (int i = 0; i < FILL_ITEMS; i++) begin
            send_item(MODE_ALLOC, IDX_W'($urandom), ENTRY_W'($urandom),
                      $urandom_range(1, CLUSTER_SIZE_BYTES));
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fte_pkg.sv
hw/rtl/fte_ram.sv
hw/rtl/fte_row_store.sv
hw/rtl/fat12_table_engine.sv
test/fat12_table_checker.sv
test/fat12_table_engine_test.sv
